[hw/rtl/atust_pkg.sv]
// Shared types, constants and helpers of the unsolicited status tracker.
package atust_pkg;

    localparam int LINE_BYTES = 64;
    localparam int LEN_W      = $clog2(LINE_BYTES + 1);
    localparam int ADDR_W     = $clog2(LINE_BYTES);
    localparam int Q_DEPTH    = 4;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROAM    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROFILE = 2'd2;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_SYSSTART = 3'd1;
    localparam logic [2:0] EV_SHUTDOWN = 3'd2;
    localparam logic [2:0] EV_CREG     = 3'd3;
    localparam logic [2:0] EV_SISW     = 3'd4;
    localparam logic [2:0] EV_SISR     = 3'd5;
    localparam logic [2:0] EV_SIS      = 3'd6;
    localparam logic [2:0] EV_OTHER    = 3'd7;

    localparam int FL_ONLINE   = 0;
    localparam int FL_SHUTDOWN = 1;
    localparam int FL_REG      = 2;
    localparam int FL_CONN     = 3;
    localparam int FL_WREADY   = 4;
    localparam int FL_W        = 5;
    localparam logic [FL_W-1:0] FLAGS_RESET = 5'b00001;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CARET = 8'h5E;

    localparam logic [15:0] MAG_MAX = 16'hFFFF;

    localparam int NAME_MAX = 9;
    localparam int N_NAMES  = 6;
    localparam int NM_SYSSTART = 0;
    localparam int NM_SHUTDOWN = 1;
    localparam int NM_CREG     = 2;
    localparam int NM_SISW     = 3;
    localparam int NM_SISR     = 4;
    localparam int NM_SIS      = 5;

    localparam logic [NAME_MAX*8-1:0] NAME_TEXT [N_NAMES] = '{
        "^SYSSTART",
        "^SHUTDOWN",
        {"+CREG:", 24'h0},
        {"^SISW:", 24'h0},
        {"^SISR:", 24'h0},
        {"^SIS:", 32'h0}
    };
    localparam logic [3:0] NAME_LEN [N_NAMES] = '{4'd9, 4'd9, 4'd6, 4'd6, 4'd6, 4'd5};

    localparam logic [LEN_W-1:0] OFF_FIRST  = LEN_W'(7);
    localparam logic [LEN_W-1:0] OFF_SECOND = LEN_W'(9);
    localparam logic [LEN_W-1:0] CREG_LONG  = LEN_W'(22);
    localparam logic [LEN_W-1:0] CREG_MID   = LEN_W'(10);
    localparam logic [LEN_W-1:0] CREG_SHORT = LEN_W'(8);

    typedef struct packed {
        logic [2:0]       ev;
        logic             ovf;
        logic [LEN_W-1:0] tlen;
    } t_cmd;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr;

    function automatic logic [7:0] name_char(input int k, input logic [3:0] p);
        logic [7:0] res;
        res = 8'h00;
        for (int i = 0; i < NAME_MAX; i++) begin
            if (p == 4'(i)) begin
                res = NAME_TEXT[k][(NAME_MAX-1-i)*8 +: 8];
            end
        end
        return res;
    endfunction

endpackage

[hw/rtl/at_unsolicited_status_tracker.sv]
// Top level: receive byte tracker for unsolicited modem status lines.
// A byte's result passes through the command queue and then the result register.
// Throughput: one byte per cycle while the queue has room; a +CREG, ^SISW or ^SISR line
// end stalls input while the back end walks the line store through one RAM read port.
// Synchronous active-low reset: parser idle, online set, all other flags clear, queue
// and result register empty; the line store is not cleared.
module at_unsolicited_status_tracker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_rx_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_online,
    output logic                            o_shutdown,
    output logic                            o_registered,
    output logic                            o_connected,
    output logic                            o_write_ready,
    output logic [2:0]                      o_line_event,
    output logic                            o_line_overflow,
    input  logic                            i_cfg_we,
    input  logic [atust_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [atust_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import atust_pkg::*;

    logic              push;
    t_cmd              push_cmd;
    logic              q_full;
    logic              q_valid;
    t_cmd              q_data;
    logic              pop;
    logic              done;
    t_wr               wr;
    logic [ADDR_W-1:0] raddr;
    logic [7:0]        rd_data;
    logic [FL_W-1:0]   flags;

    atust_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_rx_byte  (i_rx_byte),
        .i_q_full   (q_full),
        .i_done     (done),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .o_wr       (wr)
    );

    atust_ram #(
        .WIDTH (8),
        .DEPTH (LINE_BYTES)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (wr.en),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    atust_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (pop)
    );

    atust_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_q_valid       (q_valid),
        .i_q_data        (q_data),
        .o_pop           (pop),
        .o_done          (done),
        .o_raddr         (raddr),
        .i_rd_data       (rd_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_flags         (flags),
        .o_line_event    (o_line_event),
        .o_line_overflow (o_line_overflow)
    );

    assign o_online      = flags[FL_ONLINE];
    assign o_shutdown    = flags[FL_SHUTDOWN];
    assign o_registered  = flags[FL_REG];
    assign o_connected   = flags[FL_CONN];
    assign o_write_ready = flags[FL_WREADY];

endmodule

[hw/rtl/atust_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module atust_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/atust_front.sv]
// Front end: accepts receive bytes, tracks the line phase, stores and classifies lines.
module atust_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_q_full,
    input  logic                 i_done,
    output logic                 o_push,
    output atust_pkg::t_cmd      o_cmd,
    output atust_pkg::t_wr       o_wr
);
    import atust_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_NAME = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;
    localparam logic [1:0] PH_END  = 2'd3;

    logic [1:0]         r_phase, n_phase;
    logic [LEN_W-1:0]   r_len, n_len;
    logic               r_ovf, n_ovf;
    logic [N_NAMES-1:0] r_match, n_match;
    logic               r_zseen, n_zseen;
    logic [LEN_W-1:0]   r_zpos, n_zpos;
    logic               r_busy, n_busy;

    logic               accept;
    logic               do_store;
    logic               start;
    logic [LEN_W-1:0]   pos;
    logic [N_NAMES-1:0] base_match;
    logic               base_zseen;
    logic [N_NAMES-1:0] has;
    logic [2:0]         ev;
    logic [LEN_W-1:0]   tlen;

    assign o_in_stall = r_busy || i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign tlen       = r_zseen ? r_zpos : r_len;

    always_comb begin
        for (int k = 0; k < N_NAMES; k++) begin
            has[k] = r_match[k] && (r_len >= LEN_W'(NAME_LEN[k]));
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_ovf    = r_ovf;
        n_match  = r_match;
        n_zseen  = r_zseen;
        n_zpos   = r_zpos;
        n_busy   = i_done ? 1'b0 : r_busy;
        do_store = 1'b0;
        start    = 1'b0;
        ev       = EV_NONE;

        unique case (r_phase)
            PH_IDLE: begin
                if (i_rx_byte == CH_PLUS || i_rx_byte == CH_CARET) begin
                    start    = 1'b1;
                    do_store = 1'b1;
                    n_ovf    = 1'b0;
                    n_phase  = PH_NAME;
                end
            end
            PH_NAME: begin
                do_store = 1'b1;
                if (i_rx_byte == CH_CR) begin
                    n_phase = PH_IDLE;
                    if (has[NM_SYSSTART]) begin
                        ev = EV_SYSSTART;
                    end else if (has[NM_SHUTDOWN]) begin
                        ev = EV_SHUTDOWN;
                    end else begin
                        ev = EV_OTHER;
                    end
                end else if (i_rx_byte == CH_COLON) begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (i_rx_byte == CH_CR) begin
                    n_phase = PH_END;
                end else begin
                    do_store = 1'b1;
                end
            end
            PH_END: begin
                n_phase = PH_IDLE;
                if (i_rx_byte == CH_LF) begin
                    if (has[NM_CREG]) begin
                        ev = EV_CREG;
                    end else if (has[NM_SISW]) begin
                        ev = EV_SISW;
                    end else if (has[NM_SISR]) begin
                        ev = EV_SISR;
                    end else if (has[NM_SIS]) begin
                        ev = EV_SIS;
                    end else begin
                        ev = EV_OTHER;
                    end
                    if (ev == EV_CREG || ev == EV_SISW || ev == EV_SISR) begin
                        n_busy = 1'b1;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        pos        = start ? '0 : r_len;
        base_match = start ? '1 : r_match;
        base_zseen = start ? 1'b0 : r_zseen;

        o_wr.en   = 1'b0;
        o_wr.addr = pos[ADDR_W-1:0];
        o_wr.data = i_rx_byte;

        if (do_store) begin
            if (pos < LEN_W'(LINE_BYTES)) begin
                o_wr.en = 1'b1;
                n_len   = pos + LEN_W'(1);
                for (int k = 0; k < N_NAMES; k++) begin
                    n_match[k] = base_match[k];
                    if (pos < LEN_W'(NAME_LEN[k])
                            && i_rx_byte != name_char(k, pos[3:0])) begin
                        n_match[k] = 1'b0;
                    end
                end
                n_zseen = base_zseen;
                if (!base_zseen && i_rx_byte == 8'h00) begin
                    n_zseen = 1'b1;
                    n_zpos  = pos;
                end
            end else begin
                n_ovf = 1'b1;
            end
        end

        if (!accept) begin
            n_phase = r_phase;
            n_len   = r_len;
            n_ovf   = r_ovf;
            n_match = r_match;
            n_zseen = r_zseen;
            n_zpos  = r_zpos;
            n_busy  = i_done ? 1'b0 : r_busy;
            o_wr.en = 1'b0;
        end

        o_push     = accept;
        o_cmd.ev   = ev;
        o_cmd.ovf  = n_ovf;
        o_cmd.tlen = tlen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_busy  <= 1'b0;
            r_match <= '0;
            r_zseen <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_ovf   <= n_ovf;
            r_busy  <= n_busy;
            r_match <= n_match;
            r_zseen <= n_zseen;
        end
        r_zpos <= n_zpos;
    end

endmodule

[hw/rtl/atust_queue.sv]
// Short command queue between the front end and the back end.
module atust_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  atust_pkg::t_cmd i_data,
    output logic            o_full,
    output logic            o_valid,
    output atust_pkg::t_cmd o_data,
    input  logic            i_pop
);
    import atust_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (i_push) begin
            n_wp = (r_wp == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

[hw/rtl/atust_back.sv]
// Back end: walks stored fields, updates status flags and holds the result register.
module atust_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [atust_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [atust_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                            i_q_valid,
    input  atust_pkg::t_cmd                 i_q_data,
    output logic                            o_pop,
    output logic                            o_done,
    output logic [atust_pkg::ADDR_W-1:0]    o_raddr,
    input  logic [7:0]                      i_rd_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [atust_pkg::FL_W-1:0]      o_flags,
    output logic [2:0]                      o_line_event,
    output logic                            o_line_overflow
);
    import atust_pkg::*;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_ADDR = 2'd1;
    localparam logic [1:0] B_CHAR = 2'd2;
    localparam logic [1:0] B_DONE = 2'd3;

    function automatic logic val_eq(input logic neg, input logic [15:0] mag,
                                    input logic [15:0] x);
        return (mag == x) && (!neg || mag == 16'd0);
    endfunction

    logic [1:0]       r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [LEN_W-1:0] r_pos, n_pos;
    logic             r_neg, n_neg;
    logic [15:0]      r_mag, n_mag;
    logic             r_sgn, n_sgn;
    logic             r_second, n_second;
    logic             r_a_ok, n_a_ok;
    logic [FL_W-1:0]  r_flags, n_flags;
    logic             r_out_valid, n_out_valid;
    logic [2:0]       r_out_ev, n_out_ev;
    logic             r_out_ovf, n_out_ovf;
    logic [7:0]       r_home, r_roam;
    logic [3:0]       r_prof;

    logic             out_free;
    logic             walk;
    logic [7:0]       c;
    logic             is_blank;
    logic             is_sign;
    logic             is_digit;
    logic [7:0]       dig;
    logic [19:0]      acc;
    logic [LEN_W-1:0] creg_off;

    assign out_free = !r_out_valid || !i_out_stall;
    assign walk     = (i_q_data.ev == EV_CREG) || (i_q_data.ev == EV_SISW)
                   || (i_q_data.ev == EV_SISR);
    assign c        = (r_pos < r_cmd.tlen) ? i_rd_data : 8'h00;
    assign is_blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    assign is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign dig      = c - CH_ZERO;
    assign acc      = ({4'b0, r_mag} << 3) + ({4'b0, r_mag} << 1) + 20'(dig[3:0]);
    assign o_raddr  = r_pos[ADDR_W-1:0];

    always_comb begin
        if (i_q_data.tlen > CREG_LONG) begin
            creg_off = OFF_SECOND;
        end else if (i_q_data.tlen > CREG_MID) begin
            creg_off = OFF_FIRST;
        end else if (i_q_data.tlen > CREG_SHORT) begin
            creg_off = OFF_SECOND;
        end else begin
            creg_off = OFF_FIRST;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_pos       = r_pos;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_sgn       = r_sgn;
        n_second    = r_second;
        n_a_ok      = r_a_ok;
        n_flags     = r_flags;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_ev    = r_out_ev;
        n_out_ovf   = r_out_ovf;
        o_pop       = 1'b0;
        o_done      = 1'b0;

        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    if (walk) begin
                        o_pop    = 1'b1;
                        n_cmd    = i_q_data;
                        n_pos    = (i_q_data.ev == EV_CREG) ? creg_off : OFF_FIRST;
                        n_neg    = 1'b0;
                        n_mag    = '0;
                        n_sgn    = 1'b0;
                        n_second = 1'b0;
                        n_state  = B_ADDR;
                    end else if (out_free) begin
                        o_pop = 1'b1;
                        case (i_q_data.ev)
                            EV_SYSSTART: n_flags = '0;
                            EV_SHUTDOWN: begin
                                n_flags[FL_ONLINE]   = 1'b0;
                                n_flags[FL_SHUTDOWN] = 1'b1;
                            end
                            default: ;
                        endcase
                        n_out_valid = 1'b1;
                        n_out_ev    = i_q_data.ev;
                        n_out_ovf   = i_q_data.ovf;
                    end
                end
            end
            B_ADDR: begin
                n_state = B_CHAR;
            end
            B_CHAR: begin
                if (!r_sgn && is_blank) begin
                    n_pos   = r_pos + LEN_W'(1);
                    n_state = B_ADDR;
                end else if (!r_sgn && is_sign) begin
                    n_neg   = (c == CH_MINUS);
                    n_sgn   = 1'b1;
                    n_pos   = r_pos + LEN_W'(1);
                    n_state = B_ADDR;
                end else if (is_digit) begin
                    n_sgn   = 1'b1;
                    n_mag   = (acc > 20'(MAG_MAX)) ? MAG_MAX : acc[15:0];
                    n_pos   = r_pos + LEN_W'(1);
                    n_state = B_ADDR;
                end else if (r_cmd.ev != EV_CREG && !r_second) begin
                    n_a_ok   = val_eq(r_neg, r_mag, {12'b0, r_prof});
                    n_second = 1'b1;
                    n_pos    = OFF_SECOND;
                    n_neg    = 1'b0;
                    n_mag    = '0;
                    n_sgn    = 1'b0;
                    n_state  = B_ADDR;
                end else begin
                    n_state = B_DONE;
                end
            end
            B_DONE: begin
                if (out_free) begin
                    case (r_cmd.ev)
                        EV_CREG: begin
                            if (!(r_neg && r_mag == 16'd1)) begin
                                n_flags[FL_REG] = val_eq(r_neg, r_mag, {8'b0, r_home})
                                               || val_eq(r_neg, r_mag, {8'b0, r_roam});
                            end
                        end
                        EV_SISW: begin
                            if (r_a_ok && !r_neg && r_mag == 16'd1) begin
                                n_flags[FL_CONN]   = 1'b1;
                                n_flags[FL_WREADY] = 1'b1;
                            end
                        end
                        EV_SISR: begin
                            if (r_a_ok && !r_neg && r_mag == 16'd2) begin
                                n_flags[FL_CONN] = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                    n_out_valid = 1'b1;
                    n_out_ev    = r_cmd.ev;
                    n_out_ovf   = r_cmd.ovf;
                    o_done      = 1'b1;
                    n_state     = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_flags     <= FLAGS_RESET;
            r_out_valid <= 1'b0;
            r_home      <= 8'd1;
            r_roam      <= 8'd5;
            r_prof      <= 4'd0;
        end else begin
            r_state     <= n_state;
            r_flags     <= n_flags;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HOME:    r_home <= i_cfg_data;
                    CFG_ROAM:    r_roam <= i_cfg_data;
                    CFG_PROFILE: r_prof <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
        end
        r_cmd     <= n_cmd;
        r_pos     <= n_pos;
        r_neg     <= n_neg;
        r_mag     <= n_mag;
        r_sgn     <= n_sgn;
        r_second  <= n_second;
        r_a_ok    <= n_a_ok;
        r_out_ev  <= n_out_ev;
        r_out_ovf <= n_out_ovf;
    end

    assign o_out_valid     = r_out_valid;
    assign o_flags         = r_flags;
    assign o_line_event    = r_out_ev;
    assign o_line_overflow = r_out_ovf;

endmodule

[hw/rtl/atust_checker.sv]
// Port-level checker for the status tracker and its bind to the top level.
module atust_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_online,
    input logic       o_shutdown,
    input logic       o_registered,
    input logic       o_connected,
    input logic       o_write_ready,
    input logic [2:0] o_line_event,
    input logic       o_line_overflow
);
    import atust_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("stalled result dropped");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_line_event) && $stable(o_line_overflow) && $stable(o_online)
            && $stable(o_shutdown) && $stable(o_registered) && $stable(o_connected)
            && $stable(o_write_ready))
        else $error("stalled result changed");

    a_sysstart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_event == EV_SYSSTART |->
            !o_online && !o_shutdown && !o_registered && !o_connected && !o_write_ready)
        else $error("sysstart left a flag set");

    a_shutdown_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_event == EV_SHUTDOWN |-> !o_online && o_shutdown)
        else $error("shutdown event without shutdown flags");

endmodule

bind at_unsolicited_status_tracker atust_checker u_atust_checker (.*);

[sim/at_unsolicited_status_tracker_tb.sv]
// Self-checking testbench: random and directed modem byte streams against a status predictor.
`timescale 1ns / 100ps

module at_unsolicited_status_tracker_tb;
    import atust_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 16;
    localparam int LONG_HOLD   = 200;
    localparam int PHASE_ITEMS = 260;

    typedef enum logic [1:0] {PH_IDLE, PH_NAME, PH_DATA, PH_END} t_scan_phase;

    typedef struct packed {
        logic       online;
        logic       shutdown;
        logic       registered;
        logic       connected;
        logic       write_ready;
        logic [2:0] line_event;
        logic       line_overflow;
    } t_status;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic [7:0]           i_rx_byte   = 8'h00;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_online;
    logic                 o_shutdown;
    logic                 o_registered;
    logic                 o_connected;
    logic                 o_write_ready;
    logic [2:0]           o_line_event;
    logic                 o_line_overflow;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_HOME;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;

    // predictor state and its copy of the registers
    t_scan_phase     scan_phase = PH_IDLE;
    logic [7:0]      line_buf [LINE_BYTES];
    int              line_len   = 0;
    logic [FL_W-1:0] flag_bits  = FLAGS_RESET;
    bit              line_ovf   = 1'b0;
    int              cfg_home    = 1;
    int              cfg_roam    = 5;
    int              cfg_profile = 0;

    logic [7:0] rx_backlog [$];
    t_status    status_due [$];

    int errors;
    int xfer_count;
    int result_count;
    int queued_items;
    int cfg_writes;
    int cycle_count;
    int event_seen [8];
    int send_idle_pct;
    int recv_idle_pct;
    int send_gap;
    int recv_gap;
    int hold_left;
    bit hold_req;
    bit hold_done;

    at_unsolicited_status_tracker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_online        (o_online),
        .o_shutdown      (o_shutdown),
        .o_registered    (o_registered),
        .o_connected     (o_connected),
        .o_write_ready   (o_write_ready),
        .o_line_event    (o_line_event),
        .o_line_overflow (o_line_overflow),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void store_char(logic [7:0] b);
        if (line_len < LINE_BYTES) begin
            line_buf[line_len] = b;
            line_len++;
        end else begin
            line_ovf = 1'b1;
        end
    endfunction

    function automatic bit line_starts(string nm);
        if (line_len < nm.len()) return 1'b0;
        for (int i = 0; i < nm.len(); i++) begin
            if (line_buf[i] != nm[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int text_end();
        int i;
        i = 0;
        while (i < line_len && line_buf[i] != 8'h00) i++;
        return i;
    endfunction

    function automatic logic [7:0] char_at(int pos, int tlen);
        return (pos < tlen) ? line_buf[pos] : 8'h00;
    endfunction

    function automatic int read_number(int pos, int tlen);
        int         mag;
        bit         neg;
        logic [7:0] c;
        mag = 0;
        neg = 1'b0;
        c = char_at(pos, tlen);
        while (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            pos++;
            c = char_at(pos, tlen);
        end
        if (c == CH_PLUS || c == CH_MINUS) begin
            neg = (c == CH_MINUS);
            pos++;
            c = char_at(pos, tlen);
        end
        while (c >= CH_ZERO && c <= CH_NINE) begin
            mag = mag * 10 + int'(c - CH_ZERO);
            if (mag > int'(MAG_MAX)) mag = int'(MAG_MAX);
            pos++;
            c = char_at(pos, tlen);
        end
        return neg ? -mag : mag;
    endfunction

    function automatic logic [2:0] close_data_line();
        int tlen;
        int off;
        int a;
        int c;
        tlen = text_end();
        if (line_starts("+CREG:")) begin
            if (tlen > int'(CREG_LONG)) off = int'(OFF_SECOND);
            else if (tlen > int'(CREG_MID)) off = int'(OFF_FIRST);
            else if (tlen > int'(CREG_SHORT)) off = int'(OFF_SECOND);
            else off = int'(OFF_FIRST);
            a = read_number(off, tlen);
            if (a != -1) flag_bits[FL_REG] = (a == cfg_home || a == cfg_roam);
            return EV_CREG;
        end
        if (line_starts("^SISW:")) begin
            a = read_number(int'(OFF_FIRST), tlen);
            c = read_number(int'(OFF_SECOND), tlen);
            if (a == cfg_profile && c == 1) begin
                flag_bits[FL_CONN]   = 1'b1;
                flag_bits[FL_WREADY] = 1'b1;
            end
            return EV_SISW;
        end
        if (line_starts("^SISR:")) begin
            a = read_number(int'(OFF_FIRST), tlen);
            c = read_number(int'(OFF_SECOND), tlen);
            if (a == cfg_profile && c == 2) flag_bits[FL_CONN] = 1'b0;
            return EV_SISR;
        end
        if (line_starts("^SIS:")) return EV_SIS;
        return EV_OTHER;
    endfunction

    function automatic t_status track_byte(logic [7:0] b);
        logic [2:0] ev;
        t_status    r;
        ev = EV_NONE;
        case (scan_phase)
            PH_IDLE: if (b == CH_PLUS || b == CH_CARET) begin
                line_len = 0;
                line_ovf = 1'b0;
                store_char(b);
                scan_phase = PH_NAME;
            end
            PH_NAME: begin
                if (b == CH_CR) begin
                    if (line_starts("^SYSSTART")) begin
                        flag_bits = '0;
                        ev = EV_SYSSTART;
                    end else if (line_starts("^SHUTDOWN")) begin
                        flag_bits[FL_ONLINE]   = 1'b0;
                        flag_bits[FL_SHUTDOWN] = 1'b1;
                        ev = EV_SHUTDOWN;
                    end else begin
                        ev = EV_OTHER;
                    end
                    scan_phase = PH_IDLE;
                end else if (b == CH_COLON) begin
                    scan_phase = PH_DATA;
                end
                store_char(b);
            end
            PH_DATA: begin
                if (b == CH_CR) scan_phase = PH_END;
                else store_char(b);
            end
            default: begin
                if (b == CH_LF) ev = close_data_line();
                scan_phase = PH_IDLE;
            end
        endcase
        r.online        = flag_bits[FL_ONLINE];
        r.shutdown      = flag_bits[FL_SHUTDOWN];
        r.registered    = flag_bits[FL_REG];
        r.connected     = flag_bits[FL_CONN];
        r.write_ready   = flag_bits[FL_WREADY];
        r.line_event    = ev;
        r.line_overflow = line_ovf;
        return r;
    endfunction

    task automatic check_field(string nm, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, want, got);
            errors++;
        end
    endtask

    task automatic check_status();
        t_status want;
        result_count++;
        event_seen[o_line_event]++;
        if (status_due.size() == 0) begin
            $display("%0t: result transfer with nothing outstanding", $time);
            errors++;
        end else begin
            want = status_due.pop_front();
            check_field("online", want.online, o_online);
            check_field("shutdown", want.shutdown, o_shutdown);
            check_field("registered", want.registered, o_registered);
            check_field("connected", want.connected, o_connected);
            check_field("write_ready", want.write_ready, o_write_ready);
            check_field("line_event", want.line_event, o_line_event);
            check_field("line_overflow", want.line_overflow, o_line_overflow);
        end
    endtask

    always @(posedge i_clk) begin : sender
        bit valid_nx;
        valid_nx = i_in_valid;
        if (!i_rst_n) begin
            valid_nx = 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                status_due.push_back(track_byte(i_rx_byte));
                xfer_count++;
                valid_nx = 1'b0;
                if ($urandom_range(99) < send_idle_pct) send_gap = $urandom_range(6, 1);
            end
            if (!valid_nx) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (rx_backlog.size() > 0) begin
                    i_rx_byte <= rx_backlog.pop_front();
                    valid_nx = 1'b1;
                end
            end
        end
        i_in_valid <= valid_nx;
    end

    always @(posedge i_clk) begin : receiver
        bit stall_nx;
        stall_nx = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) check_status();
            if (hold_req && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_nx = 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap--;
                stall_nx = 1'b1;
            end else if ($urandom_range(99) < recv_idle_pct) begin
                recv_gap = $urandom_range(6, 1);
            end
        end
        i_out_stall <= stall_nx;
    end

    task automatic queue_byte(logic [7:0] b);
        rx_backlog.push_back(b);
        queued_items++;
    endtask

    task automatic queue_text(string s);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
    endtask

    task automatic queue_name_line(string s);
        queue_text(s);
        queue_byte(CH_CR);
    endtask

    task automatic queue_data_line(string s);
        queue_text(s);
        queue_byte(CH_CR);
        queue_byte(CH_LF);
    endtask

    function automatic string num_text(int hint);
        case ($urandom_range(9))
            1: return "-1";
            2: return $sformatf("%0d", $urandom_range(9));
            3: return $sformatf("%0d", $urandom_range(300));
            4: return $sformatf("%0d", $urandom_range(999999, 65530));
            5: return $sformatf("+%0d", hint);
            6: return $sformatf("-%0d", $urandom_range(20));
            7: return "";
            8: return $sformatf("  %0d", hint);
            default: return $sformatf("%0d", hint);
        endcase
    endfunction

    task automatic queue_random_line();
        string      body;
        string      prof_txt;
        int         pick;
        int         n;
        int         hint;
        logic [7:0] b;
        pick = $urandom_range(99);
        hint = $urandom_range(1) ? cfg_home : cfg_roam;
        if (pick < 25) begin
            case ($urandom_range(3))
                0: body = {"+CREG: ", num_text(hint)};
                1: body = $sformatf("+CREG: %0d,%s", $urandom_range(2), num_text(hint));
                2: body = $sformatf("+CREG: %s,\"%04X\",\"%04X\"", num_text(hint),
                                    $urandom_range(65535), $urandom_range(65535));
                default: body = $sformatf("+CREG: %0d,%s,\"%04X\",\"%04X\"", $urandom_range(2),
                                          num_text(hint), $urandom_range(65535),
                                          $urandom_range(65535));
            endcase
            queue_data_line(body);
        end else if (pick < 49) begin
            if ($urandom_range(3) == 0) prof_txt = num_text(cfg_profile);
            else if ($urandom_range(1)) prof_txt = $sformatf("%0d", cfg_profile);
            else prof_txt = $sformatf("%0d", $urandom_range(9));
            if (pick < 37) body = {"^SISW: ", prof_txt, ",", num_text(1)};
            else body = {"^SISR: ", prof_txt, ",", num_text(2)};
            if ($urandom_range(2) == 0) body = {body, $sformatf(",%0d", $urandom_range(1500))};
            queue_data_line(body);
        end else if (pick < 54) begin
            queue_data_line($sformatf("^SIS: %0d,%0d,%0d,\"Remote\"", $urandom_range(9),
                                      $urandom_range(1), $urandom_range(9999)));
        end else if (pick < 60) begin
            queue_name_line("^SYSSTART");
        end else if (pick < 66) begin
            queue_name_line("^SHUTDOWN");
        end else if (pick < 71) begin
            body = $urandom_range(1) ? "^" : "+";
            n = $urandom_range(10, 1);
            repeat (n) body = {body, $sformatf("%c", $urandom_range(90, 65))};
            queue_name_line(body);
        end else if (pick < 76) begin
            queue_data_line($sformatf("+CSQ: %0d,99", $urandom_range(31)));
        end else if (pick < 90) begin
            case ($urandom_range(4))
                0: begin
                    queue_text($sformatf("%s %0d,1", $urandom_range(1) ? "+CREG:" : "^SISW:",
                                         cfg_profile));
                    queue_byte(CH_CR);
                    b = $urandom_range(255);
                    if (b == CH_LF) b = CH_CARET;
                    queue_byte(b);
                end
                1: begin
                    queue_text($sformatf("+CREG: %0d", hint));
                    queue_byte(8'h00);
                    queue_data_line($sformatf(",%0d", $urandom_range(9)));
                end
                2: begin
                    queue_text($urandom_range(1) ? "+CREG: 0,1," : "^SISW: 0,1,");
                    n = $urandom_range(90, 50);
                    repeat (n) queue_byte(8'($urandom_range(126, 32)));
                    queue_data_line("");
                end
                3: begin
                    queue_byte(CH_CARET);
                    n = $urandom_range(80, 55);
                    repeat (n) queue_byte(8'($urandom_range(90, 65)));
                    queue_byte(CH_CR);
                end
                default: begin
                    case ($urandom_range(4))
                        0: queue_name_line("^SYS");
                        1: queue_name_line("^SHUTDOWNX");
                        2: queue_data_line("+CRE: 1");
                        3: queue_name_line("^SISW 0,1");
                        default: queue_data_line("^SI: 0");
                    endcase
                end
            endcase
        end else begin
            n = $urandom_range(4, 1);
            repeat (n) rx_backlog.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DAT_W'(val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_HOME:    cfg_home = val & 8'hFF;
            CFG_ROAM:    cfg_roam = val & 8'hFF;
            CFG_PROFILE: cfg_profile = val & 4'hF;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic wait_drained();
        while (rx_backlog.size() != 0 || i_in_valid || status_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
        $display("** at_unsolicited_status_tracker: FAILED **");
        $finish;
    end

    initial begin
        int home_val;
        int roam_val;
        int prof_val;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 30;
        recv_idle_pct = 30;

        queue_name_line("^SYSSTART");
        queue_data_line("+CREG: 0,1");
        queue_data_line("^SISW: 0,1");
        queue_data_line("^SISR: 0,2");
        queue_data_line("^SIS: 0,0,2200");
        queue_data_line("+CREG: -1,\"00AB\"");
        queue_data_line("+CREG: 5,\"00AB\",\"1234\"");
        queue_data_line("+CREG: 2,-1,\"00AB\",\"1234\"");
        queue_data_line("+CREG: 99999");
        queue_name_line("^SHUTDOWN");
        queue_data_line("+COPS: 0");
        queue_name_line("^AB");
        queue_text("+CREG: 0,5");
        queue_byte(CH_CR);
        queue_byte(CH_CARET);
        queue_text("+CREG: 1");
        queue_byte(8'h00);
        queue_data_line("5");
        queue_text("+CREG: 0,1,");
        repeat (60) queue_byte("A");
        queue_data_line("");
        queue_byte(8'hFF);
        wait_drained();

        for (int ph = 1; ph <= 6; ph++) begin
            case (ph)
                1: begin
                    home_val = 0;
                    roam_val = 255;
                    prof_val = 9;
                end
                2: begin
                    home_val = 255;
                    roam_val = 0;
                    prof_val = 0;
                end
                3: begin
                    home_val = $urandom_range(12);
                    roam_val = $urandom_range(12);
                    prof_val = $urandom_range(9);
                end
                4: begin
                    home_val = 1;
                    roam_val = 5;
                    prof_val = 3;
                end
                5: begin
                    home_val = $urandom_range(255);
                    roam_val = $urandom_range(20);
                    prof_val = $urandom_range(9);
                end
                default: begin
                    home_val = 3;
                    roam_val = 3;
                    prof_val = 9;
                end
            endcase
            write_cfg(CFG_HOME, home_val);
            write_cfg(CFG_ROAM, roam_val);
            write_cfg(CFG_PROFILE, prof_val);
            send_idle_pct = (ph == 6) ? 0 : $urandom_range(50, 5);
            recv_idle_pct = (ph == 6) ? 0 : $urandom_range(50, 5);
            queued_items = 0;
            while (queued_items < PHASE_ITEMS) queue_random_line();
            if (ph == 2) hold_req = 1'b1;
            wait_drained();
        end

        $display("Run moved %0d bytes, checked %0d status results, made %0d register writes.",
                 xfer_count, result_count, cfg_writes);
        $display("Events: sysstart %0d shutdown %0d creg %0d sisw %0d sisr %0d sis %0d other %0d",
                 event_seen[EV_SYSSTART], event_seen[EV_SHUTDOWN], event_seen[EV_CREG],
                 event_seen[EV_SISW], event_seen[EV_SISR], event_seen[EV_SIS],
                 event_seen[EV_OTHER]);
        if (errors == 0) begin
            $display("** at_unsolicited_status_tracker: PASSED **");
        end else begin
            $display("** at_unsolicited_status_tracker: FAILED **");
        end
        $finish;
    end

endmodule
